FILE: hdl/hashed_saturating_history_table_unit_assert.svh
// Assertion macros shared by the checker of the history table unit.
`ifndef HASHED_SATURATING_HISTORY_TABLE_UNIT_ASSERT_SVH
`define HASHED_SATURATING_HISTORY_TABLE_UNIT_ASSERT_SVH

`define HSHT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define HSHT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/hsht_pkg.sv
// Package of constants, types and codes for the history table unit.
package hsht_pkg;
  localparam int BANKS = 4;
  localparam int BANK_W = $clog2(BANKS);
  localparam int INDEX_BITS = 16;
  localparam int ADDR_W = BANK_W + INDEX_BITS;
  localparam int DEPTH = 1 << ADDR_W;
  localparam int TOKEN_W = 10;
  localparam int KEY_W = 2 * TOKEN_W;
  localparam int LIMIT_W = 15;
  localparam int SCORE_W = 16;
  localparam int QUO_W = 30;
  localparam int CNT_W = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd16384;
  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
  localparam logic [CNT_W-1:0] HASH_LAST = 5'd5;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_HASH, ST_READ, ST_WAIT, ST_MAG, ST_DIV, ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    HS_X_C1LO, HS_X_C1HI, HS_MIX, HS_Y_C2LO, HS_YLO_C2HI, HS_YHI_C2LO
  } hash_step_t;

  typedef struct packed {
    logic       load;
    logic       hash_en;
    hash_step_t hash_step;
    logic       rd_en;
    logic       wait_cap;
    logic       mag_en;
    logic       div_step;
    logic       finish;
    logic       clr_en;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic update;
    logic clr_done;
  } status_t;
endpackage

FILE: hdl/hsht_ram.sv
// Generic single-port-write, registered-read RAM.
module hsht_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: hdl/hsht_ctrl.sv
// Controller state machine of the history table unit.
module hsht_ctrl import hsht_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);
  state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    unique case (state)
      ST_CLEAR: begin
        if (status.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_HASH;
          cnt_next = '0;
        end
      end
      ST_HASH: begin
        if (status.skip) begin
          state_next = ST_FINISH;
        end else if (cnt == HASH_LAST) begin
          state_next = ST_READ;
          cnt_next = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_READ: state_next = ST_WAIT;
      ST_WAIT: state_next = status.update ? ST_MAG : ST_FINISH;
      ST_MAG: begin
        state_next = ST_DIV;
        cnt_next = '0;
      end
      ST_DIV: begin
        if (cnt == DIV_LAST) begin
          state_next = ST_FINISH;
          cnt_next = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_FINISH: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_CLEAR: cmd.clr_en = 1'b1;
      ST_IDLE: cmd.load = start;
      ST_HASH: begin
        cmd.hash_en = !status.skip;
        cmd.hash_step = hash_step_t'(cnt[2:0]);
      end
      ST_READ: cmd.rd_en = 1'b1;
      ST_WAIT: cmd.wait_cap = 1'b1;
      ST_MAG: cmd.mag_en = 1'b1;
      ST_DIV: cmd.div_step = 1'b1;
      ST_FINISH: cmd.finish = 1'b1;
      default: cmd = '0;
    endcase
  end
endmodule

FILE: hdl/hsht_dp.sv
// Datapath: hash, score memory, gravity arithmetic and serial divider.
module hsht_dp import hsht_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  input  logic                      req_type,
  input  logic [TOKEN_W-1:0]        previous_token,
  input  logic [TOKEN_W-1:0]        current_token,
  input  logic [BANK_W-1:0]         bank_select,
  input  logic signed [SCORE_W-1:0] bonus,
  input  logic                      score_limit_we,
  input  logic [LIMIT_W-1:0]        score_limit,
  output status_t                   status,
  output logic                      done,
  output logic signed [SCORE_W-1:0] score
);
  logic [LIMIT_W-1:0] limit_reg, lim;
  logic kind, skip_r;
  logic [KEY_W-1:0] key;
  logic [BANK_W-1:0] bank;
  logic signed [SCORE_W-1:0] bonus_r, old;
  logic [63:0] acc, y, mixed;
  logic [ADDR_W-1:0] addr_r, clr_cnt, rd_addr, waddr;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [LIMIT_W-1:0] rem;
  logic [QUO_W-1:0] quo;
  logic [LIMIT_W:0] shifted;
  logic [LIMIT_W+1:0] diff;
  logic signed [LIMIT_W+1:0] lim_s, bonus_x, b_cl;
  logic [LIMIT_W-1:0] mag, old_mag;
  logic signed [31:0] q_s, next_v, lim_w;
  logic signed [SCORE_W-1:0] new_score, wdata;
  logic [SCORE_W-1:0] rdata;
  logic we;

  assign lim = (limit_reg == '0) ? LIMIT_W'(1) : limit_reg;
  assign mixed = acc ^ (acc >> 31);
  assign rd_addr = {bank, mixed[INDEX_BITS-1:0]};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.mag_en) begin
      mul_a = {17'b0, old_mag};
      mul_b = {17'b0, mag};
    end else begin
      unique case (cmd.hash_step)
        HS_X_C1LO: begin mul_a = {12'b0, key}; mul_b = MIX_C1[31:0]; end
        HS_X_C1HI: begin mul_a = {12'b0, key}; mul_b = MIX_C1[63:32]; end
        HS_Y_C2LO: begin mul_a = y[31:0]; mul_b = MIX_C2[31:0]; end
        HS_YLO_C2HI: begin mul_a = y[31:0]; mul_b = MIX_C2[63:32]; end
        HS_YHI_C2LO: begin mul_a = y[63:32]; mul_b = MIX_C2[31:0]; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end
  assign mul_p = mul_a * mul_b;

  assign lim_s = signed'({2'b0, lim});
  assign bonus_x = 17'(bonus_r);
  always_comb begin
    priority if (bonus_x > lim_s) b_cl = lim_s;
    else if (bonus_x < -lim_s) b_cl = -lim_s;
    else b_cl = bonus_x;
  end
  assign mag = b_cl[LIMIT_W+1] ? LIMIT_W'(-b_cl) : b_cl[LIMIT_W-1:0];
  assign old_mag = old[SCORE_W-1] ? LIMIT_W'(-old) : old[LIMIT_W-1:0];

  assign shifted = {rem, quo[QUO_W-1]};
  assign diff = {1'b0, shifted} - {2'b0, lim};

  assign q_s = old[SCORE_W-1] ? -signed'({2'b0, quo}) : signed'({2'b0, quo});
  assign next_v = 32'(old) + 32'(b_cl) - q_s;
  assign lim_w = signed'({17'b0, lim});
  always_comb begin
    priority if (next_v > lim_w) new_score = SCORE_W'(lim_w);
    else if (next_v < -lim_w) new_score = SCORE_W'(-lim_w);
    else new_score = SCORE_W'(next_v);
  end

  assign we = cmd.clr_en || (cmd.finish && kind && !skip_r);
  assign waddr = cmd.clr_en ? clr_cnt : addr_r;
  assign wdata = cmd.clr_en ? '0 : new_score;

  assign status.skip = skip_r;
  assign status.update = kind;
  assign status.clr_done = cmd.clr_en && (clr_cnt == '1);

  hsht_ram #(.WIDTH(SCORE_W), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(cmd.rd_en), .raddr(rd_addr), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_reg <= LIMIT_RESET;
      clr_cnt <= '0;
      done <= 1'b0;
    end else begin
      if (score_limit_we) limit_reg <= score_limit;
      if (cmd.clr_en) clr_cnt <= clr_cnt + 1'b1;
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= req_type;
      key <= {previous_token, current_token};
      bank <= bank_select;
      bonus_r <= bonus;
      skip_r <= (previous_token == '0) || (current_token == '0);
    end
    if (cmd.hash_en) begin
      unique case (cmd.hash_step)
        HS_X_C1LO, HS_Y_C2LO: acc <= mul_p;
        HS_X_C1HI, HS_YLO_C2HI, HS_YHI_C2LO: acc <= acc + {mul_p[31:0], 32'b0};
        HS_MIX: y <= acc ^ (acc >> 27);
        default: acc <= acc;
      endcase
    end
    if (cmd.rd_en) addr_r <= rd_addr;
    if (cmd.wait_cap) old <= signed'(rdata);
    if (cmd.mag_en) begin
      quo <= mul_p[QUO_W-1:0];
      rem <= '0;
    end
    if (cmd.div_step) begin
      rem <= diff[LIMIT_W+1] ? shifted[LIMIT_W-1:0] : diff[LIMIT_W-1:0];
      quo <= {quo[QUO_W-2:0], !diff[LIMIT_W+1]};
    end
    if (cmd.finish) begin
      score <= skip_r ? '0 : (kind ? new_score : old);
    end
  end
endmodule

FILE: hdl/hashed_saturating_history_table_unit.sv
// Top level of the hashed saturating history table unit.
// After reset the unit clears its 262144-entry score memory, one entry a cycle, and holds
// busy high while it clears. An item is taken when start is high and busy low.
// Busy stays high while a read, an update or an item with a zero token is handled;
// done then pulses for one cycle with the score. The hash runs on one shared 32 by 32
// multiplier, and an update divides by the limit one quotient bit a cycle.
// Results cannot be held off, so they must be taken in the cycle they appear.
module hashed_saturating_history_table_unit import hsht_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      req_type,
  input  logic [TOKEN_W-1:0]        previous_token,
  input  logic [TOKEN_W-1:0]        current_token,
  input  logic [BANK_W-1:0]         bank_select,
  input  logic signed [SCORE_W-1:0] bonus,
  input  logic                      score_limit_we,
  input  logic [LIMIT_W-1:0]        score_limit,
  output logic                      done,
  output logic signed [SCORE_W-1:0] score
);
  cmd_t cmd;
  status_t status;

  hsht_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .status(status), .cmd(cmd), .busy(busy)
  );

  hsht_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .req_type(req_type),
    .previous_token(previous_token), .current_token(current_token),
    .bank_select(bank_select), .bonus(bonus), .score_limit_we(score_limit_we),
    .score_limit(score_limit), .status(status), .done(done), .score(score)
  );
endmodule

FILE: hdl/hsht_checker.sv
// Port-level checker of the history table unit and its bind.
`include "hashed_saturating_history_table_unit_assert.svh"
module hsht_checker import hsht_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic                      done,
  input logic signed [SCORE_W-1:0] score
);
  `HSHT_ASSERT_NEXT(a_done_pulse, done, !done)
  `HSHT_ASSERT_NEXT(a_take_busy, start && !busy, busy)
  `HSHT_ASSERT_SAME(a_done_idle, done, !busy)
  `HSHT_ASSERT_SAME(a_score_range, done, score != 16'sh8000)
endmodule

bind hashed_saturating_history_table_unit hsht_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .score(score)
);

FILE: bench/hashed_saturating_history_table_unit_tb.sv
// Self-checking testbench for the hashed saturating history table unit.
module hashed_saturating_history_table_unit_tb;
  import hsht_pkg::*;

  localparam logic REQ_READ = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic                      kind;
    logic [TOKEN_W-1:0]        prev_tok;
    logic [TOKEN_W-1:0]        cur_tok;
    logic [BANK_W-1:0]         bank;
    logic signed [SCORE_W-1:0] reward;
  } hist_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic req_type = 1'b0;
  logic [TOKEN_W-1:0] previous_token = '0;
  logic [TOKEN_W-1:0] current_token = '0;
  logic [BANK_W-1:0] bank_select = '0;
  logic signed [SCORE_W-1:0] bonus = '0;
  logic score_limit_we = 1'b0;
  logic [LIMIT_W-1:0] score_limit = '0;
  logic done;
  logic signed [SCORE_W-1:0] score;

  hist_item_t pending_items[$];
  logic signed [SCORE_W-1:0] expected_scores[$];
  logic signed [SCORE_W-1:0] shadow_scores[int];
  logic [LIMIT_W-1:0] model_limit;
  int errors = 0;
  int cycles = 0;
  int gap_left = 0;
  bit no_gaps = 1'b0;

  hashed_saturating_history_table_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .previous_token(previous_token), .current_token(current_token),
    .bank_select(bank_select), .bonus(bonus), .score_limit_we(score_limit_we),
    .score_limit(score_limit), .done(done), .score(score)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [63:0] mix_key(logic [63:0] v);
    v = v ^ (v >> 30);
    v = v * 64'hbf58476d1ce4e5b9;
    v = v ^ (v >> 27);
    v = v * 64'h94d049bb133111eb;
    return v ^ (v >> 31);
  endfunction

  function automatic logic signed [SCORE_W-1:0] predict_score(hist_item_t it);
    longint lim, b, mag, old, nxt;
    int at;
    lim = (model_limit == 0) ? 1 : longint'(model_limit);
    if (it.prev_tok == 0 || it.cur_tok == 0) return '0;
    at = int'(it.bank) * 65536
       + int'(mix_key(64'(it.prev_tok) * 1024 + 64'(it.cur_tok)) & 64'hFFFF);
    old = shadow_scores.exists(at) ? longint'(shadow_scores[at]) : 0;
    if (it.kind == REQ_READ) return SCORE_W'(old);
    b = longint'(it.reward);
    if (b > lim) b = lim;
    if (b < -lim) b = -lim;
    mag = (b < 0) ? -b : b;
    nxt = old + b - (old * mag) / lim;
    if (nxt > lim) nxt = lim;
    if (nxt < -lim) nxt = -lim;
    shadow_scores[at] = SCORE_W'(nxt);
    return SCORE_W'(nxt);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        expected_scores.push_back(predict_score(pending_items.pop_front()));
      end
      if (start && busy) begin
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (!no_gaps && $urandom_range(0, 9) == 0) begin
        gap_left <= $urandom_range(0, 5);
        start <= 1'b0;
      end else if (pending_items.size() > 0) begin
        hist_item_t nx;
        nx = pending_items[0];
        start <= 1'b1;
        req_type <= nx.kind;
        previous_token <= nx.prev_tok;
        current_token <= nx.cur_tok;
        bank_select <= nx.bank;
        bonus <= nx.reward;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_scores.size() == 0) begin
        $display("%0t unexpected score %0d", $time, score);
        errors <= errors + 1;
      end else begin
        logic signed [SCORE_W-1:0] want;
        want = expected_scores.pop_front();
        if (score !== want) begin
          $display("%0t score mismatch: expected %0d actual %0d", $time, want, score);
          errors <= errors + 1;
        end
      end
    end
  end

  function automatic hist_item_t random_item();
    hist_item_t it;
    int hot;
    it.kind = 1'($urandom_range(0, 1));
    hot = $urandom_range(0, 9);
    it.prev_tok = (hot < 6) ? TOKEN_W'($urandom_range(1, 6)) : TOKEN_W'($urandom_range(0, 1023));
    it.cur_tok = (hot < 6) ? TOKEN_W'($urandom_range(1, 6)) : TOKEN_W'($urandom_range(0, 1023));
    if ($urandom_range(0, 19) == 0) it.cur_tok = '0;
    it.bank = BANK_W'($urandom_range(0, 3));
    it.reward = SCORE_W'($urandom);
    if ($urandom_range(0, 3) == 0) it.reward = SCORE_W'($urandom_range(0, 400) - 200);
    return it;
  endfunction

  task automatic drain_and_settle();
    wait (pending_items.size() == 0 && expected_scores.size() == 0);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] v);
    @(posedge clk);
    score_limit_we <= 1'b1;
    score_limit <= v;
    @(posedge clk);
    score_limit_we <= 1'b0;
    model_limit = v;
  endtask

  function automatic hist_item_t make_item(logic k, int p, int c, int bk, int r);
    hist_item_t it;
    it.kind = k;
    it.prev_tok = TOKEN_W'(p);
    it.cur_tok = TOKEN_W'(c);
    it.bank = BANK_W'(bk);
    it.reward = SCORE_W'(r);
    return it;
  endfunction

  initial begin
    logic [LIMIT_W-1:0] limits[6];
    model_limit = LIMIT_RESET;
    limits = '{15'd0, 15'd1, 15'd32767, 15'd100, 15'd16384, 15'd3000};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    wait (!busy);
    pending_items.push_back(make_item(REQ_READ, 1, 1, 0, 0));
    pending_items.push_back(make_item(REQ_UPDATE, 1, 1, 0, 32767));
    pending_items.push_back(make_item(REQ_UPDATE, 1, 1, 0, -32768));
    pending_items.push_back(make_item(REQ_UPDATE, 1023, 1023, 3, 500));
    pending_items.push_back(make_item(REQ_READ, 1023, 1023, 3, 0));
    pending_items.push_back(make_item(REQ_UPDATE, 0, 5, 1, 700));
    pending_items.push_back(make_item(REQ_UPDATE, 5, 0, 2, 700));
    pending_items.push_back(make_item(REQ_READ, 0, 0, 2, -1));
    pending_items.push_back(make_item(REQ_UPDATE, 768, 768, 2, 16384));
    pending_items.push_back(make_item(REQ_UPDATE, 768, 768, 2, -16385));
    pending_items.push_back(make_item(REQ_UPDATE, 2, 3, 1, 1));
    pending_items.push_back(make_item(REQ_UPDATE, 2, 3, 1, 0));
    drain_and_settle();
    write_limit(15'd32767);
    pending_items.push_back(make_item(REQ_UPDATE, 1, 1, 0, 32767));
    pending_items.push_back(make_item(REQ_UPDATE, 1, 1, 0, 32767));
    drain_and_settle();
    write_limit(15'd10);
    pending_items.push_back(make_item(REQ_READ, 1, 1, 0, 0));
    pending_items.push_back(make_item(REQ_UPDATE, 1, 1, 0, 3));
    drain_and_settle();
    for (int ph = 0; ph < 6; ph++) begin
      write_limit(limits[ph]);
      if (ph == 5) no_gaps = 1'b1;
      for (int k = 0; k < 240; k++) pending_items.push_back(random_item());
      drain_and_settle();
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
